// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Depth, tag width, command codes, channel payloads and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 32;

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int WordW = 32;
  localparam int WideW = (TAG_WIDTH > WordW) ? TAG_WIDTH : WordW;

  typedef logic [TAG_WIDTH-1:0] spq_tag_t;
  typedef logic [7:0]           spq_prio_t;
  typedef logic [CntW-1:0]      spq_cnt_t;

  typedef enum logic [2:0] {
    CmdAdd    = 3'd0,
    CmdRmHead = 3'd1,
    CmdRmTag  = 3'd2,
    CmdExists = 3'd3,
    CmdPeek   = 3'd4,
    CmdClear  = 3'd5
  } spq_cmd_e;

  typedef enum logic [1:0] {
    OpHold   = 2'd0,
    OpInsert = 2'd1,
    OpShift  = 2'd2
  } spq_op_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } spq_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data_value;
    logic [7:0]  priority_req;
    logic [3:0]  position;
  } spq_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [4:0]  entry_count;
  } spq_out_t;

  typedef struct packed {
    logic    cap;  // latch compare flags for the incoming beat
    spq_op_e op;
  } spq_cell_ctl_t;

  function automatic spq_tag_t word_to_tag(input logic [WordW-1:0] w);
    logic [WideW-1:0] tmp;
    tmp = WideW'(w);
    return tmp[TAG_WIDTH-1:0];
  endfunction

  function automatic logic [WordW-1:0] tag_to_word(input spq_tag_t t);
    logic [WideW-1:0] tmp;
    tmp = WideW'(t);
    return tmp[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry chain
// Holds a tag and priority, compares them against the incoming beat, and
// loads from the new entry or a neighbor on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                  clk_i,
  input  wire spq_pkg::spq_cell_ctl_t ctl_i,
  input  wire spq_pkg::spq_tag_t      cmp_tag_i,
  input  wire spq_pkg::spq_prio_t     cmp_prio_i,
  input  wire spq_pkg::spq_tag_t      new_tag_i,
  input  wire spq_pkg::spq_prio_t     new_prio_i,
  input  wire logic                  occ_i,
  input  wire spq_pkg::spq_tag_t      left_tag_i,
  input  wire spq_pkg::spq_prio_t     left_prio_i,
  input  wire logic                  left_keep_i,
  input  wire spq_pkg::spq_tag_t      right_tag_i,
  input  wire spq_pkg::spq_prio_t     right_prio_i,
  input  wire logic                  found_i,
  output spq_pkg::spq_tag_t           tag_o,
  output spq_pkg::spq_prio_t          prio_o,
  output logic                       keep_o,
  output logic                       match_o,
  output logic                       found_o
);
  import spq_pkg::*;

  spq_tag_t  tag_q, tag_d;
  spq_prio_t prio_q, prio_d;
  logic      match_q, ge_q;

  assign keep_o  = occ_i & ge_q;
  assign match_o = occ_i & match_q;
  assign found_o = found_i | match_o;

  always_comb begin
    tag_d  = tag_q;
    prio_d = prio_q;
    case (ctl_i.op)
      OpInsert: begin
        // sorted chain: keep flags form a prefix, new entry lands at its edge
        if (!keep_o) begin
          if (left_keep_i) begin
            tag_d  = new_tag_i;
            prio_d = new_prio_i;
          end else begin
            tag_d  = left_tag_i;
            prio_d = left_prio_i;
          end
        end
      end
      OpShift: begin
        if (found_o) begin
          tag_d  = right_tag_i;
          prio_d = right_prio_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
    if (ctl_i.cap) begin
      match_q <= (tag_q == cmp_tag_i);
      ge_q    <= (prio_q >= cmp_prio_i);
    end
  end

  assign tag_o  = tag_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire

// ===== design/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted tagged queue with FIFO order on ties
// A chain of DEPTH cells kept ordered by priority, highest at the head.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one command beat
//   (add, remove head, remove by tag, exists, peek, clear). Output channel
//   out_valid_o / out_stall_i returns one result beat per command: ok,
//   data word and entry count after the command.
//   On the accept edge the block takes the beat and every cell registers its
//   tag-equal and priority-compare flags. The execute state then resolves
//   the first-match chain across the cells, updates all cells in parallel
//   (shift right on insert, shift left on remove) and loads the output
//   register. No new command is taken until the current one completes.
//   A new command is taken while a result waits; if the receiver still
//   stalls when the next command completes, that command holds in its
//   execute state until the output register frees up.
//   Reset clears the entry count, state and output valid; cell contents
//   are don't-care until written.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire spq_pkg::spq_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output spq_pkg::spq_out_t     out_data_o
);
  import spq_pkg::*;

  spq_state_e state_q, state_d;
  logic       accept, fire;

  logic [2:0] cmd_q;
  spq_tag_t   tag_q;
  spq_prio_t  prio_q;
  logic [3:0] pos_q;

  spq_cnt_t count_q, count_d;
  logic     out_valid_q, out_valid_d;
  spq_out_t out_q, out_d;

  spq_cell_ctl_t ctl;
  spq_tag_t      in_tag;

  spq_tag_t  cell_tag  [DEPTH];
  spq_prio_t cell_prio [DEPTH];
  logic      cell_keep [DEPTH];
  logic      cell_match[DEPTH];
  logic      found_w   [DEPTH+1];

  assign in_tag = word_to_tag(in_data_i.data_value);

  // ---- FSM ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      StIdle: in_stall_o = 1'b0;
      StExec: begin
        in_stall_o = 1'b1;
        fire       = !out_valid_q || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // ---- cell control ----
  always_comb begin
    ctl.cap = accept;
    ctl.op  = OpHold;
    if (fire) begin
      case (cmd_q)
        CmdAdd:    if (count_q < CntW'(DEPTH)) ctl.op = OpInsert;
        CmdRmHead: if (count_q != '0) ctl.op = OpShift;
        CmdRmTag:  ctl.op = OpShift;
        default:   ctl.op = OpHold;
      endcase
    end
  end

  // seed the remove chain at the head for remove-head
  assign found_w[0] = (cmd_q == CmdRmHead);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_tag_t  l_tag, r_tag;
    spq_prio_t l_prio, r_prio;
    logic      l_keep;

    if (i == 0) begin : g_head
      assign l_tag  = tag_q;
      assign l_prio = prio_q;
      assign l_keep = 1'b1;
    end else begin : g_mid
      assign l_tag  = cell_tag[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_keep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_tag  = '0;
      assign r_prio = '0;
    end else begin : g_body
      assign r_tag  = cell_tag[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .cmp_tag_i   (in_tag),
      .cmp_prio_i  (in_data_i.priority_req),
      .new_tag_i   (tag_q),
      .new_prio_i  (prio_q),
      .occ_i       (CntW'(i) < count_q),
      .left_tag_i  (l_tag),
      .left_prio_i (l_prio),
      .left_keep_i (l_keep),
      .right_tag_i (r_tag),
      .right_prio_i(r_prio),
      .found_i     (found_w[i]),
      .tag_o       (cell_tag[i]),
      .prio_o      (cell_prio[i]),
      .keep_o      (cell_keep[i]),
      .match_o     (cell_match[i]),
      .found_o     (found_w[i+1])
    );
  end

  // ---- result ----
  spq_tag_t first_tag, peek_tag;
  logic     any_match;

  always_comb begin
    first_tag = '0;
    peek_tag  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i] && !found_w[i]) first_tag = first_tag | cell_tag[i];
      if (int'(pos_q) == i) peek_tag = cell_tag[i];
    end
  end

  // with the head seed off, the chain end flags any match
  assign any_match = found_w[DEPTH];

  always_comb begin
    count_d = count_q;
    out_d   = out_q;
    if (fire) begin
      out_d.ok       = 1'b0;
      out_d.data_out = '0;
      case (cmd_q)
        CmdAdd: begin
          if (count_q < CntW'(DEPTH)) begin
            out_d.ok = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        CmdRmHead: begin
          if (count_q != '0) begin
            out_d.ok       = 1'b1;
            out_d.data_out = tag_to_word(cell_tag[0]);
            count_d        = count_q - 1'b1;
          end
        end
        CmdRmTag: begin
          if (any_match) begin
            out_d.ok       = 1'b1;
            out_d.data_out = tag_to_word(first_tag);
            count_d        = count_q - 1'b1;
          end
        end
        CmdExists: out_d.ok = any_match;
        CmdPeek: begin
          if ((CntW + 1)'(pos_q) < (CntW + 1)'(count_q)) begin
            out_d.ok       = 1'b1;
            out_d.data_out = tag_to_word(peek_tag);
          end
        end
        CmdClear: begin
          out_d.ok = 1'b1;
          count_d  = '0;
        end
        default: ;
      endcase
      out_d.entry_count = 5'(count_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cmd_q  <= in_data_i.cmd;
      tag_q  <= in_tag;
      prio_q <= in_data_i.priority_req;
      pos_q  <= in_data_i.position;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("command not held busy after accept");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("completed command produced no result beat");

  a_rmhead_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_q == CmdRmHead && count_q != '0) |=>
      (count_q == $past(count_q) - 1'b1))
    else $error("remove head did not drop one entry");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("entry count changed outside a command");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stable_priority_queue
// A directed table runs first. Random command streams follow, biased to fill
// and drain the queue. Each reply is checked against the table or a behavioral
// copy of the ordered tag list. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------

module tb;
  import spq_pkg::*;

  // codes outside the command set; the block must ignore them
  localparam logic [2:0] CmdRsvd6 = 3'd6;
  localparam logic [2:0] CmdRsvd7 = 3'd7;

  localparam int RandItems = 1000;
  localparam int HoldAt    = 300;
  localparam int DrainAt   = 650;

  typedef struct packed {
    spq_in_t  beat;
    logic     typed;
    spq_out_t want;
  } plan_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  spq_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  spq_out_t out_data_o;

  stable_priority_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ordered contents, head at index 0
  spq_tag_t  q_tag  [DEPTH];
  spq_prio_t q_prio [DEPTH];
  int        fill_level = 0;

  spq_out_t  pending_replies[$];
  plan_row_t plan_q[$];
  int        errors     = 0;
  int        burst_left = 0;
  bit        hold_go    = 1'b0;
  bit        hold_done  = 1'b0;

  function automatic int find_tag(input spq_tag_t tag);
    for (int i = 0; i < fill_level; i++) begin
      if (q_tag[i] == tag) return i;
    end
    return fill_level;
  endfunction

  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < fill_level; i++) begin
      q_tag[i]  = q_tag[i+1];
      q_prio[i] = q_prio[i+1];
    end
    fill_level--;
  endfunction

  function automatic spq_out_t predict_reply(input spq_in_t c);
    spq_out_t r;
    spq_tag_t tag;
    int       at;
    r   = '0;
    tag = spq_tag_t'(c.data_value);
    case (c.cmd)
      CmdAdd: begin
        if (fill_level < DEPTH) begin
          // goes behind every entry of equal or higher priority
          at = 0;
          while (at < fill_level && q_prio[at] >= c.priority_req) at++;
          for (int i = fill_level; i > at; i--) begin
            q_tag[i]  = q_tag[i-1];
            q_prio[i] = q_prio[i-1];
          end
          q_tag[at]  = tag;
          q_prio[at] = c.priority_req;
          fill_level++;
          r.ok = 1'b1;
        end
      end
      CmdRmHead: begin
        if (fill_level > 0) begin
          r.data_out = 32'(q_tag[0]);
          drop_entry(0);
          r.ok = 1'b1;
        end
      end
      CmdRmTag: begin
        at = find_tag(tag);
        if (at < fill_level) begin
          r.data_out = 32'(q_tag[at]);
          drop_entry(at);
          r.ok = 1'b1;
        end
      end
      CmdExists: r.ok = (find_tag(tag) < fill_level);
      CmdPeek: begin
        if (int'(c.position) < fill_level) begin
          r.data_out = 32'(q_tag[c.position]);
          r.ok = 1'b1;
        end
      end
      CmdClear: begin
        fill_level = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = 5'(fill_level);
    return r;
  endfunction

  function automatic spq_in_t random_beat(input int add_pct);
    spq_in_t b;
    int      r;
    b.data_value   = $urandom;
    b.priority_req = 8'($urandom);
    b.position     = 4'($urandom);
    // tags: often ones already stored, plus a small pool for duplicates
    r = $urandom_range(0, 9);
    if (r < 5 && fill_level > 0) begin
      b.data_value = 32'(q_tag[$urandom_range(0, fill_level - 1)]);
    end else if (r < 7) begin
      b.data_value = $urandom_range(0, 7);
    end else if (r == 7) begin
      b.data_value = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    // narrow priority spread gives plenty of ties
    r = $urandom_range(0, 3);
    if (r == 0) begin
      b.priority_req = 8'($urandom_range(0, 3));
    end else if (r == 1) begin
      b.priority_req = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end
    if ($urandom_range(0, 1) != 0 && fill_level > 0) begin
      b.position = 4'($urandom_range(0, fill_level - 1));
    end
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      b.cmd = CmdAdd;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25)      b.cmd = CmdRmHead;
      else if (r < 50) b.cmd = CmdRmTag;
      else if (r < 68) b.cmd = CmdExists;
      else if (r < 90) b.cmd = CmdPeek;
      else if (r < 93) b.cmd = CmdClear;
      else             b.cmd = ($urandom_range(0, 1) != 0) ? CmdRsvd6 : CmdRsvd7;
    end
    return b;
  endfunction

  task automatic plan_row(input logic [2:0] cmd, input logic [31:0] dval,
                          input logic [7:0] prio, input logic [3:0] pos,
                          input logic typed, input logic ok,
                          input logic [31:0] dout, input logic [4:0] cnt);
    plan_row_t row;
    row.beat  = '{cmd: cmd, data_value: dval, priority_req: prio, position: pos};
    row.typed = typed;
    row.want  = '{ok: ok, data_out: dout, entry_count: cnt};
    plan_q.push_back(row);
  endtask

  // drive one beat, wait for it to be taken, then maybe open a gap
  task automatic push_beat(input spq_in_t beat, input logic typed, input spq_out_t want);
    spq_out_t pred;
    int       gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_reply(beat);
    pending_replies.push_back(typed ? want : pred);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // reply checker
  always @(posedge clk_i) begin
    spq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply %p", $time, out_data_o);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data_o.ok !== want.ok) begin
          $display("%0t: ok exp %0b got %0b", $time, want.ok, out_data_o.ok);
          errors++;
        end
        if (out_data_o.data_out !== want.data_out) begin
          $display("%0t: data_out exp %h got %h", $time, want.data_out,
                   out_data_o.data_out);
          errors++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                   out_data_o.entry_count);
          errors++;
        end
      end
    end
  end

  // receiver: stall pattern re-picked at random from four modes, one long hold-off
  initial begin
    int rx_mode;
    int rx_cyc;
    rx_mode = 0;
    rx_cyc  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (150) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (rx_cyc % 8 >= 5);
        endcase
        rx_cyc++;
      end
    end
  end

  initial begin
    int      done_cnt;
    int      phase;
    bit      paused;
    spq_in_t beat;
    int      add_pct [3];
    add_pct  = '{70, 40, 15};
    done_cnt = 0;
    phase    = 1;
    paused   = 1'b0;

    //       cmd        data          prio   pos    t  ok  data_out      cnt
    plan_row(CmdRmHead, 32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);
    plan_row(CmdPeek,   32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);
    plan_row(CmdExists, 32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);
    plan_row(CmdRmTag,  32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);
    plan_row(CmdRsvd6,  32'hFFFFFFFF, 8'hFF, 4'd15, 1, 0,  32'h0,        5'd0);
    plan_row(CmdRsvd7,  32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);
    plan_row(CmdAdd,    32'hFFFFFFFF, 8'hFF, 4'd15, 1, 1,  32'h0,        5'd1);
    plan_row(CmdAdd,    32'h0,        8'h00, 4'd0,  1, 1,  32'h0,        5'd2);
    plan_row(CmdAdd,    32'h5,        8'hFF, 4'd0,  1, 1,  32'h0,        5'd3);
    plan_row(CmdAdd,    32'h5,        8'h00, 4'd0,  1, 1,  32'h0,        5'd4);
    plan_row(CmdAdd,    32'h7,        8'h80, 4'd0,  1, 1,  32'h0,        5'd5);
    plan_row(CmdPeek,   32'h0,        8'h00, 4'd15, 1, 0,  32'h0,        5'd5);
    plan_row(CmdPeek,   32'h0,        8'h00, 4'd0,  0, 0,  32'h0,        5'd0);
    plan_row(CmdPeek,   32'h0,        8'h00, 4'd4,  0, 0,  32'h0,        5'd0);
    plan_row(CmdExists, 32'hFFFFFFFF, 8'h00, 4'd0,  1, 1,  32'h0,        5'd5);
    plan_row(CmdExists, 32'h9,        8'h00, 4'd0,  1, 0,  32'h0,        5'd5);
    plan_row(CmdRmTag,  32'h9,        8'h00, 4'd0,  1, 0,  32'h0,        5'd5);
    plan_row(CmdRmTag,  32'h5,        8'h00, 4'd0,  0, 0,  32'h0,        5'd0);
    plan_row(CmdRsvd6,  32'h7,        8'h10, 4'd1,  1, 0,  32'h0,        5'd4);
    plan_row(CmdRmHead, 32'h0,        8'h00, 4'd0,  0, 0,  32'h0,        5'd0);
    plan_row(CmdClear,  32'h0,        8'h00, 4'd0,  1, 1,  32'h0,        5'd0);
    plan_row(CmdRmHead, 32'h0,        8'h00, 4'd0,  1, 0,  32'h0,        5'd0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan_q[i]) push_beat(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);

    // fill past the top so an add to a full queue is seen early
    repeat (18) begin
      push_beat(random_beat(100), 1'b0, '0);
      done_cnt++;
    end

    while (done_cnt < RandItems) begin
      if (done_cnt % 80 == 0) phase = $urandom_range(0, 2);
      beat = random_beat(add_pct[phase]);
      push_beat(beat, 1'b0, '0);
      if (beat.cmd != CmdRsvd6 && beat.cmd != CmdRsvd7) done_cnt++;
      if (done_cnt >= HoldAt) hold_go = 1'b1;
      if (done_cnt >= DrainAt && !paused) begin
        paused = 1'b1;
        drain_wait();
      end
    end

    drain_wait();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue.sv
verif/tb.sv
